>>> hw/rtl/magenta_cipher_128_macros.svh
// ----------------------------------------------------------------------------
// magenta_cipher_128 assertion macros
// Clocked assertion wrappers; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MAGENTA_CIPHER_128_MACROS_SVH
`define MAGENTA_CIPHER_128_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset
`define MC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check that a condition in the next cycle follows from a trigger
`define MC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MC_ASSERT(lbl, expr, msg)
`define MC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/mc128_pkg.sv
// ----------------------------------------------------------------------------
// mc128_pkg
// Constants, the f exponent table and the pi and shuffle layers of the cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package mc128_pkg;

	localparam int NUM_ROUNDS    = 6;
	localparam int PI_PER_T      = 4;
	localparam int T_PER_ROUND   = 3;
	localparam int PI_PER_ROUND  = PI_PER_T * T_PER_ROUND;
	localparam int NUM_STAGES    = NUM_ROUNDS * PI_PER_ROUND;

	// Low bits of the field polynomial 0x165 and the table's last index
	localparam logic [7:0] GF_POLY_LOW = 8'h65;
	localparam int         EXP_LAST    = 255;

	// Register indexes on the configuration port
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef logic [7:0] f_tab_t [256];

	// Powers of alpha over x^8+x^6+x^5+x^2+1; the last entry is zero
	function automatic f_tab_t build_f();
		f_tab_t     t;
		logic [8:0] v;
		v = 9'd1;
		for (int i = 0; i < EXP_LAST; i++) begin
			t[i] = v[7:0];
			v = {v[7:0], 1'b0};
			if (v[8]) begin
				v = {1'b0, v[7:0] ^ GF_POLY_LOW};
			end
		end
		t[EXP_LAST] = 8'h00;
		return t;
	endfunction

	localparam f_tab_t F_TAB = build_f();

	// One pi pass: byte i pairs with byte 8+i, results interleave
	function automatic logic [127:0] pi_layer(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0]   a;
		logic [7:0]   b;
		o = '0;
		for (int i = 0; i < 8; i++) begin
			a = s[127 - 8 * i -: 8];
			b = s[63 - 8 * i -: 8];
			o[127 - 16 * i -: 8] = F_TAB[a ^ F_TAB[b]];
			o[119 - 16 * i -: 8] = F_TAB[b ^ F_TAB[a]];
		end
		return o;
	endfunction

	// Even-indexed bytes first, then the odd-indexed ones
	function automatic logic [127:0] shuffle(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int i = 0; i < 8; i++) begin
			o[127 - 8 * i -: 8] = s[127 - 16 * i -: 8];
			o[63 - 8 * i -: 8]  = s[119 - 16 * i -: 8];
		end
		return o;
	endfunction

	typedef struct packed {
		logic         dec;
		logic [63:0]  l;
		logic [63:0]  r;
		logic [127:0] c;
	} stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/magenta_cipher_128.sv
// Throughput: one item per cycle while the skid is empty; each of 72 stages runs
// one pi pass (two chained f-table lookups per byte pair), and a two-entry output
// register/skid pair keeps input open while one result waits.
// Reset: arst_n clears all valid bits and both key registers to zero at once.
// ----------------------------------------------------------------------------
// magenta_cipher_128
// Six-round Feistel cipher on 128-bit blocks, one pi pass per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magenta_cipher_128_macros.svh"

module magenta_cipher_128
	import mc128_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	// request channel
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic        req_type,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	// result channel
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic      [63:0] result_high,
	output logic      [63:0] result_low
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        cfg_wr;

	logic        pipe_vld_s [NUM_STAGES];
	stage_t      pipe_s     [NUM_STAGES];
	logic        adv;

	logic        out_v_q;
	logic        skid_v_q;
	logic [63:0] out_hi_q;
	logic [63:0] out_lo_q;
	logic [63:0] skid_hi_q;
	logic [63:0] skid_lo_q;

	logic [127:0] fin_sh;
	logic [63:0]  fin_l;
	logic [63:0]  fin_r;
	logic [63:0]  fin_hi;
	logic [63:0]  fin_lo;
	logic         last_v;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end

	// Advance the whole pipeline unless the skid holds an item
	assign adv       = !skid_v_q;
	assign req_ready = adv;

	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
		localparam int RND = k / PI_PER_ROUND;
		localparam int SUB = k % PI_PER_ROUND;

		logic [63:0]  sk;
		logic [63:0]  l_in;
		logic [63:0]  r_in;
		logic [127:0] c_in;
		logic         dec_in;
		logic         vld_in;

		// Rounds three and four use the second subkey
		assign sk = (RND == 2 || RND == 3) ? key_high_q : key_low_q;

		if (k == 0) begin : g_first
			// Swap halves on decrypt, then start round one
			always_comb begin
				dec_in = req_type;
				vld_in = req_valid;
				l_in   = req_type ? block_low : block_high;
				r_in   = req_type ? block_high : block_low;
				c_in   = {r_in, sk};
			end
		end else begin : g_next
			logic [127:0] sh;
			always_comb begin
				dec_in = pipe_s[k-1].dec;
				vld_in = pipe_vld_s[k-1];
				sh     = shuffle(pipe_s[k-1].c);
				l_in   = pipe_s[k-1].l;
				r_in   = pipe_s[k-1].r;
				c_in   = pipe_s[k-1].c;
				if (SUB == 0) begin
					// Close the previous round and load the next one
					l_in = pipe_s[k-1].r;
					r_in = pipe_s[k-1].l ^ sh[127:64];
					c_in = {r_in, sk};
				end else if (SUB % PI_PER_T == 0) begin
					// Feed the round input back into the next T pass
					c_in = {pipe_s[k-1].r, sk} ^ sh;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_vld_s[k] <= 1'b0;
			end else if (adv) begin
				pipe_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k].dec <= dec_in;
				pipe_s[k].l   <= l_in;
				pipe_s[k].r   <= r_in;
				pipe_s[k].c   <= pi_layer(c_in);
			end
		end
	end

	// Finish round six and undo the decrypt swap
	assign last_v = pipe_vld_s[NUM_STAGES-1];
	assign fin_sh = shuffle(pipe_s[NUM_STAGES-1].c);
	assign fin_l  = pipe_s[NUM_STAGES-1].r;
	assign fin_r  = pipe_s[NUM_STAGES-1].l ^ fin_sh[127:64];
	assign fin_hi = pipe_s[NUM_STAGES-1].dec ? fin_r : fin_l;
	assign fin_lo = pipe_s[NUM_STAGES-1].dec ? fin_l : fin_r;

	// Output register with a skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !result_ready) begin
			if (adv && last_v) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= last_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !result_ready) begin
			if (adv) begin
				skid_hi_q <= fin_hi;
				skid_lo_q <= fin_lo;
			end
		end else if (skid_v_q) begin
			out_hi_q <= skid_hi_q;
			out_lo_q <= skid_lo_q;
		end else begin
			out_hi_q <= fin_hi;
			out_lo_q <= fin_lo;
		end
	end

	assign result_valid = out_v_q;
	assign result_high  = out_hi_q;
	assign result_low   = out_lo_q;

	// The skid only holds an item behind a waiting result
	`MC_ASSERT(a_skid_behind_out, !skid_v_q || out_v_q, "skid full with no result shown")
	// A full skid freezes the last stage
	`MC_ASSERT_NEXT(a_hold_on_skid, skid_v_q, $stable(pipe_vld_s[NUM_STAGES-1]), "last stage moved")
	// The skid fills only while the result side stalls
	`MC_ASSERT_NEXT(a_skid_fill, !skid_v_q && !(out_v_q && !result_ready), !skid_v_q, "skid filled")

endmodule

`default_nettype wire
